[rtl/fbpa_pkg.sv]
// ============================================================================
// fbpa_pkg : shared types and constants for the block pool allocator
// Field widths, register indexes, command and status codes, and the
// control bundle that runs from the controller to the datapath.
// ============================================================================
package fbpa_pkg;

    // Pool geometry
    localparam int unsigned MAX_BLOCKS = 1024;
    localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);

    // Field widths
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned LOG2_W    = 5;
    localparam int unsigned CNT_W     = 11;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Limits and reset values of the configuration registers
    localparam logic [LOG2_W-1:0] LOG2_LIMIT  = LOG2_W'(16);
    localparam logic [LOG2_W-1:0] LOG2_RESET  = LOG2_W'(6);
    localparam logic [CNT_W-1:0]  COUNT_LIMIT = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(1024);
    localparam logic [CNT_W-1:0]  COUNT_RESET_EFF =
        (COUNT_RESET > COUNT_LIMIT) ? COUNT_LIMIT : COUNT_RESET;
    localparam logic [CNT_W-1:0]  TOTAL_LIMIT = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_RANGE = STATUS_W'(2);

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // take the request, start the link read
        logic commit;   // update the pool and load the result register
    } fbpa_ctl_t;

endpackage

[rtl/fbpa_ctrl.sv]
// ============================================================================
// fbpa_ctrl : request sequencer of the block pool allocator
// Two-state machine that takes a request, lets the link read settle, then
// commits it into the result register; owns the result valid flag.
// ============================================================================
module fbpa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output fbpa_pkg::fbpa_ctl_t ctl
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign in_stall    = (state_reg != ST_IDLE);
    assign slot_free   = !out_valid_reg || !out_stall;
    assign ctl.capture = (state_reg == ST_IDLE) && in_valid;
    assign ctl.commit  = (state_reg == ST_EXEC) && slot_free;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/fbpa_dp.sv]
// ============================================================================
// fbpa_dp : datapath of the block pool allocator
// Configuration registers, free list head and counters, the link memory
// with its registered read port, and the result register.
// ============================================================================
module fbpa_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fbpa_pkg::fbpa_ctl_t                   ctl,
    input  logic                                  cmd,
    input  logic [fbpa_pkg::ADDR_W-1:0]           block_address,
    input  logic                                  cfg_write,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]           cfg_data,
    output logic [fbpa_pkg::STATUS_W-1:0]         status,
    output logic [fbpa_pkg::ADDR_W-1:0]           granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]            available
);

    // Configuration
    logic [fbpa_pkg::ADDR_W-1:0]   base_reg;
    logic [fbpa_pkg::LOG2_W-1:0]   log2_reg;
    logic [fbpa_pkg::CNT_W-1:0]    count_reg;

    // Pool state
    logic [fbpa_pkg::IDX_W-1:0]    head_reg;
    logic [fbpa_pkg::IDX_W-1:0]    head_next;
    logic                          nonempty_reg;
    logic                          nonempty_next;
    logic [fbpa_pkg::CNT_W-1:0]    fresh_reg;
    logic [fbpa_pkg::CNT_W-1:0]    fresh_next;
    logic [fbpa_pkg::CNT_W-1:0]    total_reg;
    logic [fbpa_pkg::CNT_W-1:0]    total_next;

    // Captured request and link read data
    logic                          op_cmd_reg;
    logic [fbpa_pkg::ADDR_W-1:0]   offset_reg;
    logic [fbpa_pkg::IDX_W-1:0]    link_rd_reg;
    logic [fbpa_pkg::IDX_W-1:0]    link_mem [fbpa_pkg::MAX_BLOCKS];

    // Result register
    logic [fbpa_pkg::STATUS_W-1:0] status_reg;
    logic [fbpa_pkg::ADDR_W-1:0]   granted_reg;
    logic [fbpa_pkg::CNT_W-1:0]    avail_reg;

    // Working signals
    logic [fbpa_pkg::LOG2_W-1:0]   eff_log2;
    logic [fbpa_pkg::CNT_W-1:0]    eff_count;
    logic [fbpa_pkg::CNT_W-1:0]    new_count;
    logic [fbpa_pkg::CNT_W-1:0]    new_count_eff;
    logic [fbpa_pkg::ADDR_W-1:0]   blk_num;
    logic                          in_range;
    logic [fbpa_pkg::CNT_W-1:0]    total_dec;
    logic [fbpa_pkg::CNT_W-1:0]    total_inc;
    logic [fbpa_pkg::IDX_W-1:0]    free_idx;
    logic [fbpa_pkg::IDX_W-1:0]    grant_idx;
    logic                          granted_ok;
    logic                          link_we;
    logic [fbpa_pkg::STATUS_W-1:0] res_status;
    logic [fbpa_pkg::ADDR_W-1:0]   res_granted;

    assign eff_log2  = (log2_reg > fbpa_pkg::LOG2_LIMIT) ? fbpa_pkg::LOG2_LIMIT : log2_reg;
    assign eff_count = (count_reg > fbpa_pkg::COUNT_LIMIT) ? fbpa_pkg::COUNT_LIMIT : count_reg;
    assign new_count = cfg_data[fbpa_pkg::CNT_W-1:0];
    assign new_count_eff =
        (new_count > fbpa_pkg::COUNT_LIMIT) ? fbpa_pkg::COUNT_LIMIT : new_count;

    // Block number of the offset; inside when below the block count
    assign blk_num   = offset_reg >> eff_log2;
    assign in_range  = (blk_num < fbpa_pkg::ADDR_W'(eff_count));
    assign free_idx  = blk_num[fbpa_pkg::IDX_W-1:0];

    assign total_dec = (total_reg != '0) ? total_reg - 1'b1 : total_reg;
    assign total_inc = (total_reg != fbpa_pkg::TOTAL_LIMIT) ? total_reg + 1'b1 : total_reg;

    always_comb
    begin
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        fresh_next    = fresh_reg;
        total_next    = total_reg;
        grant_idx     = '0;
        granted_ok    = 1'b0;
        link_we       = 1'b0;
        res_status    = fbpa_pkg::STATUS_OK;
        if (op_cmd_reg == fbpa_pkg::CMD_ALLOC)
        begin
            if (nonempty_reg)
            begin
                // pop the most recently freed block
                grant_idx     = head_reg;
                head_next     = link_rd_reg;
                total_next    = total_dec;
                nonempty_next = (total_dec > fresh_reg);
                granted_ok    = 1'b1;
            end
            else if (fresh_reg != '0)
            begin
                // take the highest untouched block
                fresh_next = fresh_reg - 1'b1;
                grant_idx  = fresh_next[fbpa_pkg::IDX_W-1:0];
                total_next = total_dec;
                granted_ok = 1'b1;
            end
            else
            begin
                res_status = fbpa_pkg::STATUS_EMPTY;
            end
        end
        else
        begin
            if (in_range)
            begin
                link_we       = 1'b1;
                head_next     = free_idx;
                nonempty_next = 1'b1;
                total_next    = total_inc;
            end
            else
            begin
                res_status = fbpa_pkg::STATUS_RANGE;
            end
        end
    end

    assign res_granted = granted_ok ?
        base_reg + (fbpa_pkg::ADDR_W'(grant_idx) << eff_log2) : '0;

    // Configuration and pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            log2_reg     <= fbpa_pkg::LOG2_RESET;
            count_reg    <= fbpa_pkg::COUNT_RESET;
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            fresh_reg    <= fbpa_pkg::COUNT_RESET_EFF;
            total_reg    <= fbpa_pkg::COUNT_RESET_EFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fbpa_pkg::CFG_BASE:
                begin
                    base_reg <= cfg_data;
                end
                fbpa_pkg::CFG_LOG2:
                begin
                    log2_reg <= cfg_data[fbpa_pkg::LOG2_W-1:0];
                end
                fbpa_pkg::CFG_COUNT:
                begin
                    // new count restarts the pool
                    count_reg    <= new_count;
                    head_reg     <= '0;
                    nonempty_reg <= 1'b0;
                    fresh_reg    <= new_count_eff;
                    total_reg    <= new_count_eff;
                end
                default:
                begin
                    base_reg <= base_reg;
                end
            endcase
        end
        else if (ctl.commit)
        begin
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            fresh_reg    <= fresh_next;
            total_reg    <= total_next;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_cmd_reg <= cmd;
            offset_reg <= block_address - base_reg;
        end
    end

    // Link memory: read at the head on capture, write on a committed free
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            link_rd_reg <= link_mem[head_reg];
        end
        if (ctl.commit && link_we)
        begin
            link_mem[free_idx] <= head_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg  <= res_status;
            granted_reg <= res_granted;
            avail_reg   <= total_next;
        end
    end

    assign status          = status_reg;
    assign granted_address = granted_reg;
    assign available       = avail_reg;

endmodule

[rtl/fixed_block_pool_allocator.sv]
// ============================================================================
// fixed_block_pool_allocator : fixed-size block pool with a LIFO free list
// Hands out block addresses from a configurable region and takes them back;
// freed blocks are reused first, then untouched blocks from the top down.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  request   in_valid, in_stall, cmd, block_address    in
//  result    out_valid, out_stall, status,             out
//            granted_address, available
//  config    cfg_write, cfg_index, cfg_data            in
//
//  A request is captured in the idle state, which issues the read of the
//  link memory at the list head; the execute state then uses the registered
//  link to update the pool and load the result register.
//  A result waiting in the output register does not hold off the next
//  request; execution holds only while a full output register is stalled.
//  Reset restores the register defaults and a full pool of untouched
//  blocks; the link memory needs no clearing pass, only pushed entries
//  are ever read. Writing the block count restarts the pool the same way.
//
module fixed_block_pool_allocator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic [fbpa_pkg::ADDR_W-1:0]           block_address,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [fbpa_pkg::STATUS_W-1:0]         status,
    output logic [fbpa_pkg::ADDR_W-1:0]           granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]            available,
    // configuration write port
    input  logic                                  cfg_write,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]           cfg_data
);

    fbpa_pkg::fbpa_ctl_t ctl;

    // Sequencer: decide when to take a request and when to commit it
    fbpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // Datapath: configuration, free list, counters, result register
    fbpa_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cmd             (cmd),
        .block_address   (block_address),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .status          (status),
        .granted_address (granted_address),
        .available       (available)
    );

    // A taken request blocks the next one while it executes
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted on two consecutive cycles");

    // Only a granted allocation carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != fbpa_pkg::STATUS_OK)) |-> (granted_address == '0))
        else $error("address reported on a failed or rejected request");

    // An empty pool has no free blocks left to count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == fbpa_pkg::STATUS_EMPTY)) |-> (available == '0))
        else $error("pool reported empty with blocks still available");

endmodule

[tb/sv/fixed_block_pool_allocator_tb.sv]
// ============================================================================
// fixed_block_pool_allocator_tb : self-checking bench for the block pool
// Drives allocate and free requests through the valid/stall request channel,
// predicts every result with a cycle-free model of the LIFO free list, and
// compares status, granted address and free count on the result channel.
// Covers register extremes, region wrap, exhaustion and counter saturation.
// ============================================================================
module fixed_block_pool_allocator_tb;

    import fbpa_pkg::*;

    // Index past the register list: a write to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
    } pool_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted;
        logic [CNT_W-1:0]    avail;
    } pool_outcome_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic                 cmd           = CMD_ALLOC;
    logic [ADDR_W-1:0]    block_address = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    granted_address;
    logic [CNT_W-1:0]     available;
    logic                 cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_BASE;
    logic [ADDR_W-1:0]    cfg_data      = '0;

    always #5 clk = ~clk;

    fixed_block_pool_allocator u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_address (granted_address),
        .available       (available),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Pool model state: registers and free list, as the block should hold them
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] pool_base;
    logic [LOG2_W-1:0] pool_log2;
    logic [CNT_W-1:0]  pool_count;
    logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]  list_top;
    logic              list_live;
    logic [CNT_W-1:0]  fresh_left;
    logic [CNT_W-1:0]  free_left;

    pool_req_t     pending_reqs [$];   // requests waiting to be driven
    pool_outcome_t pool_outcomes [$];  // results owed by the block, oldest first
    pool_req_t     drv_next;
    pool_outcome_t mon_want;

    int send_idle_pct = 30;
    int recv_idle_pct = 30;
    int err_count     = 0;

    // Clamp the block size exponent and the block count as the block does
    function automatic logic [LOG2_W-1:0] shift_of_block();
        return (pool_log2 > LOG2_LIMIT) ? LOG2_LIMIT : pool_log2;
    endfunction

    function automatic logic [CNT_W-1:0] blocks_in_pool();
        return (pool_count > COUNT_LIMIT) ? COUNT_LIMIT : pool_count;
    endfunction

    // Empty the freed list and mark every block untouched
    function automatic void restart_pool();
        list_top   = '0;
        list_live  = 1'b0;
        fresh_left = blocks_in_pool();
        free_left  = blocks_in_pool();
    endfunction

    // Apply one accepted request to the model and queue the result it owes
    function automatic void predict_pool_op(input logic op, input logic [ADDR_W-1:0] addr);
        logic [LOG2_W-1:0] lg;
        logic [IDX_W-1:0]  slot;
        logic [ADDR_W-1:0] offset;
        logic [63:0]       span;
        pool_outcome_t     res;
        lg  = shift_of_block();
        res = '{STATUS_OK, '0, '0};
        if (op == CMD_ALLOC)
        begin
            if (list_live)
            begin
                // pop the most recently freed block
                slot     = list_top;
                list_top = link_mem[slot];
                if (free_left != 0)
                    free_left--;
                list_live   = (free_left > fresh_left);
                res.granted = pool_base + (ADDR_W'(slot) << lg);
            end
            else if (fresh_left != 0)
            begin
                // take the highest untouched block
                fresh_left--;
                slot = fresh_left[IDX_W-1:0];
                if (free_left != 0)
                    free_left--;
                res.granted = pool_base + (ADDR_W'(slot) << lg);
            end
            else
            begin
                res.status = STATUS_EMPTY;
            end
        end
        else
        begin
            // region test on the wrapped offset; low offset bits drop out
            offset = addr - pool_base;
            span   = 64'(blocks_in_pool()) << lg;
            if ({32'b0, offset} < span)
            begin
                slot           = IDX_W'(offset >> lg);
                link_mem[slot] = list_top;
                list_top       = slot;
                list_live      = 1'b1;
                if (free_left != TOTAL_LIMIT)
                    free_left++;
            end
            else
            begin
                res.status = STATUS_RANGE;
            end
        end
        res.avail = free_left;
        pool_outcomes.push_back(res);
    endfunction

    function automatic void report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                            input logic [ADDR_W-1:0] got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch %0d: %s expected %h got %h", err_count, what, want, got);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: pop pending requests, hold a stalled request unchanged
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            cmd           <= CMD_ALLOC;
            block_address <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_pool_op(cmd, block_address);
            // advance only when the slot is empty or was just taken
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_next       = pending_reqs.pop_front();
                    in_valid      <= 1'b1;
                    cmd           <= drv_next.op;
                    block_address <= drv_next.addr;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each taken result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pool_outcomes.size() == 0)
                begin
                    report_mismatch("unexpected result, granted", '0, granted_address);
                end
                else
                begin
                    mon_want = pool_outcomes.pop_front();
                    if (status !== mon_want.status)
                        report_mismatch("status", ADDR_W'(mon_want.status), ADDR_W'(status));
                    if (granted_address !== mon_want.granted)
                        report_mismatch("granted_address", mon_want.granted, granted_address);
                    if (available !== mon_want.avail)
                        report_mismatch("available", ADDR_W'(mon_want.avail),
                                        ADDR_W'(available));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers, all run from the main initial block on falling edges
    // ------------------------------------------------------------------------

    // Wait until every request is taken and every result has come back,
    // then let the pipeline settle
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || pool_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one register while the block is idle and mirror it in the model
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        drain();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_BASE)
            pool_base = data;
        else if (idx == CFG_LOG2)
            pool_log2 = data[LOG2_W-1:0];
        else if (idx == CFG_COUNT)
        begin
            pool_count = data[CNT_W-1:0];
            restart_pool();
        end
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Queue random requests shaped by the current pool geometry: allocates,
    // frees of real blocks with random offset bits, and stray addresses
    task automatic queue_random_reqs(input int n, input int alloc_pct, input int noise_pct);
        logic [LOG2_W-1:0] lg;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] addr;
        lg   = shift_of_block();
        cnt  = blocks_in_pool();
        span = ADDR_W'(cnt) << lg;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                pending_reqs.push_back('{CMD_ALLOC, $urandom()});
            end
            else if (cnt == 0 || $urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 3))
                    0:       addr = $urandom();
                    1:       addr = pool_base - 1;
                    2:       addr = pool_base + span;
                    default: addr = pool_base + span - 1;
                endcase
                pending_reqs.push_back('{CMD_FREE, addr});
            end
            else
            begin
                addr = pool_base + (ADDR_W'($urandom_range(0, cnt - 1)) << lg)
                     + ($urandom() & ((ADDR_W'(1) << lg) - 1));
                pending_reqs.push_back('{CMD_FREE, addr});
            end
        end
    endtask

    // Pick a fresh pool setting; junk goes into the unused upper data bits
    task automatic random_config();
        logic [ADDR_W-1:0] junk;
        logic [ADDR_W-1:0] base;
        logic [LOG2_W-1:0] lg;
        logic [CNT_W-1:0]  cnt;
        junk = $urandom();
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = ~ADDR_W'($urandom_range(0, 4095));  // region near the top wraps
            default: base = $urandom();
        endcase
        if ($urandom_range(0, 3) == 0)
            lg = LOG2_W'($urandom_range(17, 31));
        else
            lg = LOG2_W'($urandom_range(0, 16));
        case ($urandom_range(0, 9))
            0:       cnt = '0;
            1:       cnt = CNT_W'(1024);
            2:       cnt = CNT_W'($urandom_range(1025, 2047));
            3:       cnt = CNT_W'($urandom_range(41, 1023));
            default: cnt = CNT_W'($urandom_range(1, 40));
        endcase
        set_reg(CFG_BASE, base);
        set_reg(CFG_LOG2, {junk[ADDR_W-1:LOG2_W], lg});
        if ($urandom_range(0, 4) == 0)
            set_reg(CFG_UNUSED, $urandom());
        // now and then keep the pool as it is across a base or size change
        if ($urandom_range(0, 4) != 0)
            set_reg(CFG_COUNT, {junk[ADDR_W-1:CNT_W], cnt});
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int alloc_pct;
        pool_base  = '0;
        pool_log2  = LOG2_RESET;
        pool_count = COUNT_RESET;
        restart_pool();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: 1024 blocks of 64 bytes from address zero
        pending_reqs.push_back('{CMD_ALLOC, 32'hFFFF_FFFF});  // top untouched block
        pending_reqs.push_back('{CMD_FREE,  32'hFFFF_FFFF});  // far outside
        pending_reqs.push_back('{CMD_FREE,  32'h0000_FFFF});  // last block, offset bits set
        pending_reqs.push_back('{CMD_FREE,  32'h0001_0000});  // one past the end
        pending_reqs.push_back('{CMD_FREE,  32'h0000_0000});  // never handed out
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});

        // Two blocks in a region that crosses the top of memory; exhaust it
        set_reg(CFG_COUNT, 32'd2);
        set_reg(CFG_BASE, 32'hFFFF_FFC0);
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});  // empty
        pending_reqs.push_back('{CMD_FREE,  32'h0000_003F});  // wrapped, last byte
        pending_reqs.push_back('{CMD_FREE,  32'hFFFF_FFBF});  // just below base
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});

        // Oversized exponent and count clamp to 16 and the pool maximum
        set_reg(CFG_BASE, 32'h0000_0000);
        set_reg(CFG_LOG2, 32'hFFFF_FFFF);
        set_reg(CFG_COUNT, 32'hFFFF_FFFF);
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_FREE,  32'h03FF_FFFF});
        pending_reqs.push_back('{CMD_FREE,  32'h0400_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});

        // Zero blocks: nothing to hand out, nothing inside
        set_reg(CFG_LOG2, 32'd0);
        set_reg(CFG_BASE, 32'h8000_0000);
        set_reg(CFG_COUNT, 32'd0);
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_FREE,  32'h8000_0000});

        // Write past the register list, then a single 64 KB block
        set_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        set_reg(CFG_LOG2, 32'd16);
        set_reg(CFG_COUNT, 32'd1);
        pending_reqs.push_back('{CMD_FREE,  32'h8000_FFFF});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});
        pending_reqs.push_back('{CMD_ALLOC, 32'h0000_0000});

        // Repeated frees of a full pool drive the free count into saturation,
        // then allocates pull it back down
        set_reg(CFG_BASE, $urandom());
        set_reg(CFG_LOG2, ADDR_W'($urandom_range(0, 16)));
        set_reg(CFG_COUNT, 32'd1024);
        queue_random_reqs(1026, 0, 0);
        queue_random_reqs(8, 100, 0);

        // Random chunks, one setting each
        for (int c = 0; c < 8; c++)
        begin
            random_config();
            // drop all idling for one whole chunk
            send_idle_pct = (c == 2) ? 0 : 30;
            recv_idle_pct = (c == 2) ? 0 : 30;
            alloc_pct     = 25 * $urandom_range(1, 3);
            if (c == 4)
            begin
                // hold the sender until every owed result is back
                queue_random_reqs(8, alloc_pct, 12);
                drain();
                queue_random_reqs(8, alloc_pct, 12);
            end
            else
            begin
                queue_random_reqs(16, alloc_pct, 12);
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog well past the slowest legal run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
